@@ rtl/poly1305_pkg.sv @@
// Package with the shared types and constants of the Poly1305 MAC core.
`timescale 1ns / 1ps
package poly1305_pkg;

	localparam logic [1:0] KIND_START    = 2'd0;
	localparam logic [1:0] KIND_ABSORB   = 2'd1;
	localparam logic [1:0] KIND_MULTIPLY = 2'd2;
	localparam logic [1:0] KIND_FINALIZE = 2'd3;

	localparam logic [1:0] REG_R_LOW  = 2'd0;
	localparam logic [1:0] REG_R_HIGH = 2'd1;
	localparam logic [1:0] REG_S_LOW  = 2'd2;
	localparam logic [1:0] REG_S_HIGH = 2'd3;

	localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_DRAIN = 7'b0000100,
		ST_RED1  = 7'b0001000,
		ST_RED2  = 7'b0010000,
		ST_RED3  = 7'b0100000,
		ST_WAIT  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic       acc_clear;
		logic       h_load;
		logic       add_block;
		logic       tag_load;
		logic       mul_en;
		logic [2:0] h_word;
		logic [1:0] r_word;
		logic       col_end;
		logic       red1;
		logic       red2;
		logic       red3;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

@@ rtl/poly1305_ctrl.sv @@
// Controller state machine that sequences the limb products and reduction steps.
`timescale 1ns / 1ps
module poly1305_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_kind,
	output logic                  in_ready,
	input  poly1305_pkg::status_t status,
	output poly1305_pkg::cmd_t    cmd
);

	poly1305_pkg::state_t state_q;
	logic [2:0] col_q;
	logic [2:0] row_q;
	logic [2:0] row_max;
	logic [2:0] row_min_next;
	logic [2:0] col_next;
	logic       accept;
	logic       col_end;
	logic       is_mul_kind;

	assign in_ready    = (state_q == poly1305_pkg::ST_IDLE) && status.out_free;
	assign accept      = in_valid && in_ready;
	assign is_mul_kind = in_kind inside {poly1305_pkg::KIND_ABSORB, poly1305_pkg::KIND_MULTIPLY};
	assign row_max      = (col_q > 3'd4) ? 3'd4 : col_q;
	assign col_end      = (row_q == row_max);
	assign col_next     = col_q + 3'd1;
	assign row_min_next = (col_next > 3'd3) ? (col_next - 3'd3) : 3'd0;

	always_comb begin
		logic [2:0] r_diff;
		r_diff        = col_q - row_q;
		cmd           = '0;
		cmd.acc_clear = accept && (in_kind == poly1305_pkg::KIND_START);
		cmd.h_load    = accept && is_mul_kind;
		cmd.add_block = (in_kind == poly1305_pkg::KIND_ABSORB);
		cmd.tag_load  = accept && (in_kind == poly1305_pkg::KIND_FINALIZE);
		cmd.mul_en    = (state_q == poly1305_pkg::ST_MUL);
		cmd.h_word    = row_q;
		cmd.r_word    = r_diff[1:0];
		cmd.col_end   = col_end;
		cmd.red1      = (state_q == poly1305_pkg::ST_RED1);
		cmd.red2      = (state_q == poly1305_pkg::ST_RED2);
		cmd.red3      = (state_q == poly1305_pkg::ST_RED3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= poly1305_pkg::ST_IDLE;
			col_q   <= 3'd0;
			row_q   <= 3'd0;
		end else begin
			case (state_q)
				poly1305_pkg::ST_IDLE: begin
					col_q <= 3'd0;
					row_q <= 3'd0;
					if (accept && is_mul_kind) state_q <= poly1305_pkg::ST_MUL;
				end
				poly1305_pkg::ST_MUL: begin
					if (col_end) begin
						col_q <= col_next;
						row_q <= row_min_next;
						if (col_q == 3'd7) state_q <= poly1305_pkg::ST_DRAIN;
					end else begin
						row_q <= row_q + 3'd1;
					end
				end
				poly1305_pkg::ST_DRAIN: state_q <= poly1305_pkg::ST_RED1;
				poly1305_pkg::ST_RED1:  state_q <= poly1305_pkg::ST_RED2;
				poly1305_pkg::ST_RED2:  state_q <= poly1305_pkg::ST_RED3;
				poly1305_pkg::ST_RED3:  state_q <= poly1305_pkg::ST_WAIT;
				poly1305_pkg::ST_WAIT:  state_q <= poly1305_pkg::ST_IDLE;
				default:                state_q <= poly1305_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/poly1305_dp.sv @@
// Datapath with the key registers, accumulator, shared multiplier and tag register.
`timescale 1ns / 1ps
module poly1305_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [63:0]           cfg_data,
	input  logic [127:0]          block,
	input  poly1305_pkg::cmd_t    cmd,
	output poly1305_pkg::status_t status,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [127:0]          tag
);

	logic [63:0]  r_low_q, r_high_q, s_low_q, s_high_q;
	logic [129:0] acc_q;
	logic [130:0] h_q;
	logic [63:0]  prod_s1;
	logic         valid_s1;
	logic         col_end_s1;
	logic [67:0]  col_q;
	logic [255:0] words_q;
	logic [130:0] a_q;
	logic [130:0] x_q;
	logic         out_valid_q;
	logic [127:0] tag_q;

	logic [127:0] r_c;
	logic [159:0] h_ext;
	logic [31:0]  mul_a, mul_b;
	logic [67:0]  col_sum;
	logic [125:0] p_hi;
	logic [130:0] red1_sum;
	logic [130:0] x_plus5;

	assign r_c      = {r_high_q, r_low_q} & poly1305_pkg::R_CLAMP;
	assign h_ext    = {29'd0, h_q};
	assign mul_a    = h_ext[cmd.h_word*32 +: 32];
	assign mul_b    = r_c[cmd.r_word*32 +: 32];
	assign col_sum  = col_q + {4'd0, prod_s1};
	assign p_hi     = words_q[255:130];
	assign red1_sum = {1'b0, words_q[129:0]} + {3'd0, p_hi, 2'b00} + {5'd0, p_hi};
	assign x_plus5  = x_q + 131'd5;

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign tag             = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_low_q     <= '0;
			r_high_q    <= '0;
			s_low_q     <= '0;
			s_high_q    <= '0;
			acc_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					poly1305_pkg::REG_R_LOW:  r_low_q  <= cfg_data;
					poly1305_pkg::REG_R_HIGH: r_high_q <= cfg_data;
					poly1305_pkg::REG_S_LOW:  s_low_q  <= cfg_data;
					poly1305_pkg::REG_S_HIGH: s_high_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.acc_clear) begin
				acc_q <= '0;
			end else if (cmd.red3) begin
				acc_q <= x_plus5[130] ? x_plus5[129:0] : x_q[129:0];
			end
			valid_s1 <= cmd.mul_en;
			if (cmd.tag_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.h_load) begin
			h_q   <= {1'b0, acc_q} + (cmd.add_block ? {3'b001, block} : 131'd0);
			col_q <= '0;
		end else if (valid_s1) begin
			if (col_end_s1) begin
				words_q <= {col_sum[31:0], words_q[255:32]};
				col_q   <= {32'd0, col_sum[67:32]};
			end else begin
				col_q <= col_sum;
			end
		end
		prod_s1    <= mul_a * mul_b;
		col_end_s1 <= cmd.col_end;
		if (cmd.red1) a_q <= red1_sum;
		if (cmd.red2) x_q <= {1'b0, a_q[129:0]} + (a_q[130] ? 131'd5 : 131'd0);
		if (cmd.tag_load) tag_q <= acc_q[127:0] + {s_high_q, s_low_q};
	end

endmodule

@@ rtl/poly1305_mac_core.sv @@
// Top level of the Poly1305 one-time authenticator core.
//
// Items arrive on the s_ stream: tuser carries the kind (start, absorb,
// multiply only, finalize) and tdata the 128-bit little-endian block.
// The key halves r and s are written beforehand through the cfg_ port.
// A start or finalize transaction leaves the controller idle; finalize places the tag
// in the output register, from where it leaves on the m_ stream.
// An absorb or multiply-only transaction runs through the accepting cycle, the
// limb products on the single 32x32 multiplier, a drain state, three reduction
// states and a settling state, after which s_tready rises.
// The tag appears on m_tvalid in the cycle after the finalize transaction.
// While a tag waits for m_tready, s_tready stays low, so no further input
// transaction is taken until the tag leaves, at the earliest in the same cycle.
// Reset clears the key registers, the accumulator and the output valid flag.
`timescale 1ns / 1ps
module poly1305_mac_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // block_low, block_high
	input  logic [1:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // tag_low, tag_high
);

	poly1305_pkg::cmd_t    cmd;
	poly1305_pkg::status_t status;

	poly1305_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	poly1305_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.block     (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.tag       (m_tdata)
	);

endmodule

@@ rtl/poly1305_chk.sv @@
// Port-level checker for the Poly1305 MAC core and its bind statement.
`timescale 1ns / 1ps
module poly1305_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("tag dropped or changed while stalled");

	a_final_tag: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_tuser == poly1305_pkg::KIND_FINALIZE) |=> m_tvalid)
		else $error("finalize gave no tag");

	a_absorb_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_tuser == poly1305_pkg::KIND_ABSORB) |=> !s_tready ##1 !s_tready)
		else $error("absorb not held busy");

	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_tuser == poly1305_pkg::KIND_MULTIPLY) |=> !s_tready ##1 !s_tready)
		else $error("multiply not held busy");

endmodule

bind poly1305_mac_core poly1305_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
